@@ src/hotp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// HOTP package
// Shared types, constants and SHA-1 helper functions.
// ----------------------------------------------------------------------------
package hotp_pkg;

    localparam int MAX_KEY_BYTES_DEF = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KLEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIGITS = 3'd5;

    localparam logic [159:0] SHA1_IV = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // block selector for the hash core
    typedef enum logic [1:0] {
        BLK_IPAD = 2'd0,
        BLK_IMSG = 2'd1,
        BLK_OPAD = 2'd2,
        BLK_OMSG = 2'd3
    } t_blk_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_TRUNC,
        ST_MOD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic     load_ctr;
        logic     init_hash;
        logic     load_blk;
        t_blk_sel blk_sel;
        logic     round;
        logic     add_hash;
        logic     save_inner;
        logic     trunc;
        logic     mod_step;
        logic     set_error;
    } t_cmd;

    typedef struct packed {
        logic round_last;
        logic mod_done;
        logic cfg_bad;
    } t_status;

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        if (rnd < 7'd20) return 32'h5A827999;
        else if (rnd < 7'd40) return 32'h6ED9EBA1;
        else if (rnd < 7'd60) return 32'h8F1BBCDC;
        else return 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] sha1_f(input logic [6:0] rnd,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
        if (rnd < 7'd20) return (b & c) | (~b & d);
        else if (rnd < 7'd40 || rnd >= 7'd60) return b ^ c ^ d;
        else return (b & c) | (b & d) | (c & d);
    endfunction

endpackage
`default_nettype wire

@@ src/hotp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// HOTP controller
// Sequences the four SHA-1 compressions, truncation and the modulo loop.
// ----------------------------------------------------------------------------
module hotp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire hotp_pkg::t_status i_status,
    output hotp_pkg::t_cmd        o_cmd
);

    hotp_pkg::t_state r_state, n_state;
    hotp_pkg::t_blk_sel r_blk, n_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hotp_pkg::ST_IDLE;
            r_blk   <= hotp_pkg::BLK_IPAD;
        end else begin
            r_state <= n_state;
            r_blk   <= n_blk;
        end
    end

    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        unique case (r_state)
            hotp_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = hotp_pkg::ST_CHECK;
            end
            hotp_pkg::ST_CHECK: begin
                n_blk = hotp_pkg::BLK_IPAD;
                n_state = i_status.cfg_bad ? hotp_pkg::ST_OUT : hotp_pkg::ST_LOAD;
            end
            hotp_pkg::ST_LOAD:  n_state = hotp_pkg::ST_ROUND;
            hotp_pkg::ST_ROUND: begin
                if (i_status.round_last) n_state = hotp_pkg::ST_ADD;
            end
            hotp_pkg::ST_ADD: begin
                if (r_blk == hotp_pkg::BLK_OMSG) begin
                    n_state = hotp_pkg::ST_TRUNC;
                end else begin
                    n_blk   = hotp_pkg::t_blk_sel'(r_blk + 2'd1);
                    n_state = hotp_pkg::ST_LOAD;
                end
            end
            hotp_pkg::ST_TRUNC: n_state = hotp_pkg::ST_MOD;
            hotp_pkg::ST_MOD: begin
                if (i_status.mod_done) n_state = hotp_pkg::ST_OUT;
            end
            hotp_pkg::ST_OUT: begin
                if (i_out_ready) n_state = hotp_pkg::ST_IDLE;
            end
            default: n_state = hotp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.blk_sel = r_blk;
        s_axis_tready = 1'b0;
        o_out_valid   = 1'b0;
        unique case (r_state)
            hotp_pkg::ST_IDLE: begin
                s_axis_tready  = 1'b1;
                o_cmd.load_ctr = s_axis_tvalid;
            end
            hotp_pkg::ST_CHECK: begin
                o_cmd.set_error = i_status.cfg_bad;
            end
            hotp_pkg::ST_LOAD: begin
                o_cmd.load_blk  = 1'b1;
                o_cmd.init_hash = (r_blk == hotp_pkg::BLK_IPAD) ||
                                  (r_blk == hotp_pkg::BLK_OPAD);
            end
            hotp_pkg::ST_ROUND: o_cmd.round = 1'b1;
            hotp_pkg::ST_ADD: begin
                o_cmd.add_hash   = 1'b1;
                o_cmd.save_inner = (r_blk == hotp_pkg::BLK_IMSG);
            end
            hotp_pkg::ST_TRUNC: o_cmd.trunc = 1'b1;
            hotp_pkg::ST_MOD:   o_cmd.mod_step = 1'b1;
            hotp_pkg::ST_OUT:   o_out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ src/hotp_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// HOTP datapath
// Config registers, one-round-per-cycle SHA-1 core, truncation, and a
// restoring modulo that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hotp_dp #(
    parameter int MAX_KEY_BYTES = hotp_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [hotp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [hotp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [63:0]                     i_counter,
    input  wire hotp_pkg::t_cmd                  i_cmd,
    output hotp_pkg::t_status                    o_status,
    output logic [29:0]                          o_code,
    output logic                                 o_error
);

    localparam int KLEN_W = $clog2(MAX_KEY_BYTES + 1);

    logic [255:0] r_key;
    logic [5:0]   r_key_len;
    logic [3:0]   r_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_key_len <= 6'd20;
            r_digits  <= 4'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hotp_pkg::REG_KEY0:   r_key[255:192] <= i_cfg_data;
                hotp_pkg::REG_KEY1:   r_key[191:128] <= i_cfg_data;
                hotp_pkg::REG_KEY2:   r_key[127:64]  <= i_cfg_data;
                hotp_pkg::REG_KEY3:   r_key[63:0]    <= i_cfg_data;
                hotp_pkg::REG_KLEN:   r_key_len      <= i_cfg_data[5:0];
                hotp_pkg::REG_DIGITS: r_digits       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_status.cfg_bad = (r_key_len == 6'd0) || (r_digits == 4'd0) ||
                              (r_digits > 4'd9);

    // Padded key block: byte i kept when i < min(key_length, MAX_KEY_BYTES) and i < 32
    logic [KLEN_W:0] w_klen;
    logic [511:0]    w_kpad;
    always_comb begin
        if ({{(KLEN_W+1){1'b0}}, r_key_len} > (KLEN_W+7)'(MAX_KEY_BYTES))
            w_klen = (KLEN_W+1)'(MAX_KEY_BYTES);
        else
            w_klen = (KLEN_W+1)'(r_key_len);
        for (int i = 0; i < 64; i++) begin
            if (i < 32 && (KLEN_W+1)'(i) < w_klen)
                w_kpad[511-8*i -: 8] = r_key[255-8*i -: 8];
            else
                w_kpad[511-8*i -: 8] = 8'h00;
        end
    end

    logic [63:0]  r_ctr;
    logic [159:0] r_inner;
    logic [159:0] r_h;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [511:0] r_w;     // 16-word message schedule window, w[t] in top
    logic [6:0]   r_rnd;

    logic [511:0] w_blk;
    always_comb begin
        case (i_cmd.blk_sel)
            hotp_pkg::BLK_IPAD: w_blk = w_kpad ^ {64{8'h36}};
            hotp_pkg::BLK_OPAD: w_blk = w_kpad ^ {64{8'h5C}};
            // 72-byte message: 8 counter bytes, pad, length 576 bits
            hotp_pkg::BLK_IMSG: w_blk = {r_ctr, 8'h80, 376'd0, 64'd576};
            // 84-byte message: 20 digest bytes, pad, length 672 bits
            default:            w_blk = {r_inner, 8'h80, 280'd0, 64'd672};
        endcase
    end

    logic [31:0] w_t, w_next;
    assign w_next = {r_w[447:416] ^ r_w[255:224] ^ r_w[95:64] ^ r_w[511:480]};
    assign w_t = {r_a[26:0], r_a[31:27]} + hotp_pkg::sha1_f(r_rnd, r_b, r_c, r_d)
                 + r_e + hotp_pkg::sha1_k(r_rnd) + r_w[511:480];

    assign o_status.round_last = (r_rnd == 7'd79);

    logic [159:0] w_hbase;
    assign w_hbase = i_cmd.init_hash ? hotp_pkg::SHA1_IV : r_h;

    // truncation / modulo
    logic [30:0] r_rem;
    logic [56:0] r_div;   // shifted divisor
    logic [4:0]  r_mcnt;
    logic [29:0] r_code;
    logic        r_err;

    logic [159:0] w_dig;
    logic [3:0]   w_off;
    logic [31:0]  w_bin;
    logic [29:0]  w_pw;
    assign w_dig = r_h;
    assign w_off = w_dig[3:0];
    always_comb begin
        w_bin = w_dig[159 - 8*w_off -: 32];
        case (r_digits)
            4'd1: w_pw = 30'd10;
            4'd2: w_pw = 30'd100;
            4'd3: w_pw = 30'd1000;
            4'd4: w_pw = 30'd10000;
            4'd5: w_pw = 30'd100000;
            4'd6: w_pw = 30'd1000000;
            4'd7: w_pw = 30'd10000000;
            4'd8: w_pw = 30'd100000000;
            default: w_pw = 30'd1000000000;
        endcase
    end

    assign o_status.mod_done = (r_mcnt == 5'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ctr) r_ctr <= i_counter;
        if (i_cmd.set_error) begin
            r_err  <= 1'b1;
            r_code <= '0;
        end
        if (i_cmd.load_blk) begin
            r_w   <= w_blk;
            r_rnd <= '0;
            r_h   <= w_hbase;
            {r_a, r_b, r_c, r_d, r_e} <= w_hbase;
        end
        if (i_cmd.round) begin
            r_w   <= {r_w[479:0], w_next[30:0], w_next[31]};
            r_rnd <= r_rnd + 7'd1;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_t;
        end
        if (i_cmd.add_hash) begin
            r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                    r_h[63:32] + r_d, r_h[31:0] + r_e};
            if (i_cmd.save_inner)
                r_inner <= {r_h[159:128] + r_a, r_h[127:96] + r_b,
                            r_h[95:64] + r_c, r_h[63:32] + r_d, r_h[31:0] + r_e};
        end
        if (i_cmd.trunc) begin
            r_rem  <= w_bin[30:0];
            r_div  <= {w_pw, 27'd0};  // pw << 27 covers 31-bit values for pw >= 10
            r_mcnt <= 5'd28;
            r_err  <= 1'b0;
        end
        if (i_cmd.mod_step) begin
            if (r_mcnt != 5'd0) begin
                if ({26'd0, r_rem} >= r_div) r_rem <= 31'({26'd0, r_rem} - r_div);
                r_div  <= {1'b0, r_div[56:1]};
                r_mcnt <= r_mcnt - 5'd1;
            end else begin
                r_code <= r_rem[29:0];
            end
        end
    end

    assign o_code  = r_code;
    assign o_error = r_err;

endmodule
`default_nettype wire

@@ src/hotp_code_generator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// HOTP code generator top
// Counter in, HMAC-SHA1 HOTP code out.
// ----------------------------------------------------------------------------
// One word at a time: a counter is taken when idle; four SHA-1 compressions
// of 80 rounds, one round per cycle, each with a load and an add step, follow
// a check step, then come a truncate step and the modulo loop, and the code
// appears on m_axis and holds until taken. The next counter is taken only once
// the controller is back in idle, so words do not overlap. With a bad key
// length or digit count the check step goes straight to the output with error
// set and code zero. Configuration writes are taken any cycle but must only happen
// while idle.
module hotp_code_generator_top #(
    parameter int MAX_KEY_BYTES = hotp_pkg::MAX_KEY_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [hotp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [hotp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [63:0]                     s_axis_tdata,  // [63:0] counter
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [31:0]                          m_axis_tdata   // [29:0] code, [30] error
);

    hotp_pkg::t_cmd    w_cmd;
    hotp_pkg::t_status w_status;
    logic [29:0]       w_code;
    logic              w_err;

    hotp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    hotp_dp #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_counter (s_axis_tdata),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_code    (w_code),
        .o_error   (w_err)
    );

    assign m_axis_tdata = {1'b0, w_err, w_code};

endmodule
`default_nettype wire
